@@ src/fbce_pkg.sv @@
// Shared types and constants of the flash backup command engine.
package fbce_pkg;

    // Default sizes of the store and of one erase sector
    localparam int unsigned MEM_BYTES_DEF    = 131072;
    localparam int unsigned SECTOR_BYTES_DEF = 4096;

    // A mapped address never exceeds one bank bit over a 16-bit offset
    localparam int unsigned MAX_ADDR_W = 17;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Access kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_FLASH_KIND = 1'b0;
    localparam logic CFG_CHIP_ID    = 1'b1;

    // Backup part kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_64K  = 2'd1;
    localparam logic [1:0] KIND_128K = 2'd2;

    // Back-end operations
    typedef logic [2:0] t_op;
    localparam t_op OP_READ   = 3'd0;  // read a byte of the store
    localparam t_op OP_CONST  = 3'd1;  // return a byte known at classification
    localparam t_op OP_WRITE  = 3'd2;  // program one byte
    localparam t_op OP_SECTOR = 3'd3;  // erase the sector holding addr
    localparam t_op OP_CHIP   = 3'd4;  // erase the whole store

    // One queued operation
    typedef struct packed {
        t_op                   op;
        logic [MAX_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } t_cmd;

endpackage

@@ src/fbce_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
module fbce_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fbce_front.sv @@
// Front end: config registers, unlock/mode/bank tracking, address mapping, classification.
module fbce_front #(
    parameter int unsigned MEM_BYTES = 131072
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_req_type,
    input  logic [15:0]    i_offset,
    input  logic [7:0]     i_wdata,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_wdata,
    output logic           o_push,
    output fbce_pkg::t_cmd o_cmd
);
    import fbce_pkg::*;

    // Mode codes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_ID      = 3'd1;
    localparam logic [2:0] MODE_ERASE   = 3'd2;
    localparam logic [2:0] MODE_PROGRAM = 3'd3;
    localparam logic [2:0] MODE_BANK    = 3'd4;

    // Command bytes and magic offsets
    localparam logic [15:0] OFF_CMD     = 16'h5555;
    localparam logic [15:0] OFF_UNLOCK  = 16'h2AAA;
    localparam logic [7:0]  UNLOCK_A    = 8'hAA;
    localparam logic [7:0]  UNLOCK_B    = 8'h55;
    localparam logic [7:0]  CMD_ID      = 8'h90;
    localparam logic [7:0]  CMD_EXIT    = 8'hF0;
    localparam logic [7:0]  CMD_ERASE   = 8'h80;
    localparam logic [7:0]  CMD_CHIP    = 8'h10;
    localparam logic [7:0]  CMD_PROGRAM = 8'hA0;
    localparam logic [7:0]  CMD_BANK    = 8'hB0;
    localparam logic [7:0]  CMD_SECTOR  = 8'h30;

    // Part sizes; the large one capped at the store size
    localparam int unsigned PART_BIG_I = (MEM_BYTES < 131072) ? MEM_BYTES : 131072;
    localparam logic [MAX_ADDR_W:0] PART_SMALL = (MAX_ADDR_W+1)'(65536);
    localparam logic [MAX_ADDR_W:0] PART_BIG   = (MAX_ADDR_W+1)'(PART_BIG_I);

    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_chip_id, n_chip_id;
    logic [2:0]  r_mode, n_mode;
    logic        r_bank, n_bank;
    logic [7:0]  r_unl1, n_unl1;
    logic [7:0]  r_unl2, n_unl2;

    logic                  supported;
    logic                  unlocked;
    logic [MAX_ADDR_W:0]   full_addr;
    logic [MAX_ADDR_W:0]   part;
    logic [MAX_ADDR_W:0]   wrap_addr;
    logic [MAX_ADDR_W-1:0] map_addr;

    assign supported = (r_kind == KIND_64K) || (r_kind == KIND_128K);
    assign unlocked  = (r_unl1 == UNLOCK_A) && (r_unl2 == UNLOCK_B);

    // (bank * 64K + offset) mod part size; value stays below twice the part
    assign full_addr = {1'b0, r_bank, i_offset};
    assign part      = (r_kind == KIND_64K) ? PART_SMALL : PART_BIG;
    assign wrap_addr = (full_addr >= part) ? (full_addr - part) : full_addr;
    assign map_addr  = wrap_addr[MAX_ADDR_W-1:0];

    // Classification and state update
    always_comb begin
        n_kind    = r_kind;
        n_chip_id = r_chip_id;
        n_mode    = r_mode;
        n_bank    = r_bank;
        n_unl1    = r_unl1;
        n_unl2    = r_unl2;
        o_push    = 1'b0;
        o_cmd     = '{op: OP_READ, addr: map_addr, data: i_wdata};

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLASH_KIND: n_kind = i_cfg_wdata[1:0];
                CFG_CHIP_ID:    n_chip_id = i_cfg_wdata;
                default: ;
            endcase
        end

        if (i_accept) begin
            if (i_req_type == REQ_READ) begin
                o_push = 1'b1;
                if (!supported) begin
                    o_cmd.op   = OP_CONST;
                    o_cmd.data = 8'h00;
                end else if (r_mode == MODE_ID && i_offset == 16'd1) begin
                    o_cmd.op   = OP_CONST;
                    o_cmd.data = r_chip_id[15:8];
                end else if (r_mode == MODE_ID && i_offset == 16'd0) begin
                    o_cmd.op   = OP_CONST;
                    o_cmd.data = r_chip_id[7:0];
                end
            end else if (supported) begin
                if (r_mode == MODE_PROGRAM) begin
                    o_push    = 1'b1;
                    o_cmd.op  = OP_WRITE;
                    n_mode    = MODE_IDLE;
                end else if (i_offset == OFF_CMD) begin
                    if (unlocked) begin
                        case (i_wdata)
                            CMD_ID:      n_mode = MODE_ID;
                            CMD_EXIT:    n_mode = MODE_IDLE;
                            CMD_ERASE:   n_mode = MODE_ERASE;
                            CMD_PROGRAM: n_mode = MODE_PROGRAM;
                            CMD_BANK:    n_mode = MODE_BANK;
                            CMD_CHIP: begin
                                if (r_mode == MODE_ERASE) begin
                                    o_push   = 1'b1;
                                    o_cmd.op = OP_CHIP;
                                end
                            end
                            default: ;
                        endcase
                        n_unl1 = 8'h00;
                        n_unl2 = 8'h00;
                    end else begin
                        n_unl1 = i_wdata;
                    end
                end else if (i_offset == OFF_UNLOCK) begin
                    n_unl2 = i_wdata;
                end else if (i_offset == 16'd0 && r_mode == MODE_BANK) begin
                    n_bank = i_wdata[0];
                    n_mode = MODE_IDLE;
                end else if (r_mode == MODE_ERASE && i_wdata == CMD_SECTOR) begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_SECTOR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_128K;
            r_chip_id <= 16'd2498;
            r_mode    <= MODE_IDLE;
            r_bank    <= 1'b0;
            r_unl1    <= 8'h00;
            r_unl2    <= 8'h00;
        end else begin
            r_kind    <= n_kind;
            r_chip_id <= n_chip_id;
            r_mode    <= n_mode;
            r_bank    <= n_bank;
            r_unl1    <= n_unl1;
            r_unl2    <= n_unl2;
        end
    end

endmodule

@@ src/fbce_queue.sv @@
// Short command queue decoupling the front end from the back end.
module fbce_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fbce_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output fbce_pkg::t_cmd o_cmd
);
    import fbce_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ src/fbce_back.sv @@
// Back end: executes queued reads, byte programs and erase sweeps over the store RAM.
module fbce_back #(
    parameter int unsigned MEM_BYTES    = fbce_pkg::MEM_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = fbce_pkg::SECTOR_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fbce_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_strobe,
    output logic [7:0]     o_rdata
);
    import fbce_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned CNT_W  = $clog2(MEM_BYTES + SECTOR_BYTES) + 1;
    localparam logic [CNT_W-1:0] MEM_END = CNT_W'(MEM_BYTES);
    localparam logic [CNT_W-1:0] SEC_LEN = CNT_W'(SECTOR_BYTES);

    // Sector number by reciprocal multiplication, exact for any ADDR_W-bit address
    localparam int unsigned RECIP_SH = ADDR_W + $clog2(SECTOR_BYTES);
    localparam int unsigned RECIP_W  = ADDR_W + 2;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES));

    // Back-end states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEEK = 2'd2;
    localparam logic [1:0] S_FILL = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_end, n_end;
    logic              r_clearing, n_clearing;
    logic              r_const, n_const;
    logic [7:0]        r_cval, n_cval;
    logic [ADDR_W-1:0] r_quot, n_quot;

    logic [ADDR_W+RECIP_W-1:0] quot_prod;
    logic [CNT_W-1:0]  sec_base;
    logic [CNT_W-1:0]  base_next;
    logic [CNT_W-1:0]  cnt_inc;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_q;

    assign quot_prod  = i_cmd.addr[ADDR_W-1:0] * RECIP_M;
    assign sec_base   = CNT_W'(r_quot) * SEC_LEN;
    assign base_next  = sec_base + SEC_LEN;
    assign cnt_inc    = r_cnt + 1'b1;
    assign o_clearing = r_clearing;
    assign o_rdata    = r_const ? r_cval : ram_q;

    // Operation sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_end      = r_end;
        n_clearing = r_clearing;
        n_const    = r_const;
        n_cval     = r_cval;
        n_quot     = r_quot;
        o_pop      = 1'b0;
        o_strobe   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt[ADDR_W-1:0];
        ram_wdata  = 8'hFF;
        ram_re     = 1'b0;
        ram_raddr  = i_cmd.addr[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_READ: begin
                            ram_re  = 1'b1;
                            n_const = 1'b0;
                            n_state = S_READ;
                        end
                        OP_CONST: begin
                            n_const = 1'b1;
                            n_cval  = i_cmd.data;
                            n_state = S_READ;
                        end
                        OP_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = i_cmd.addr[ADDR_W-1:0];
                            ram_wdata = i_cmd.data;
                        end
                        OP_SECTOR: begin
                            n_quot  = ADDR_W'(quot_prod >> RECIP_SH);
                            n_state = S_SEEK;
                        end
                        OP_CHIP: begin
                            n_cnt   = '0;
                            n_end   = MEM_END;
                            n_state = S_FILL;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                o_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_SEEK: begin
                // sector bounds, clipped at the end of the store
                n_cnt   = sec_base;
                n_end   = (base_next > MEM_END) ? MEM_END : base_next;
                n_state = S_FILL;
            end
            S_FILL: begin
                ram_we = 1'b1;
                n_cnt  = cnt_inc;
                if (cnt_inc == r_end) begin
                    n_clearing = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_cnt      <= '0;
            r_end      <= MEM_END;
            r_clearing <= 1'b1;
            r_const    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_end      <= n_end;
            r_clearing <= n_clearing;
            r_const    <= n_const;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cval <= n_cval;
        r_quot <= n_quot;
    end

    // Backup store
    fbce_ram #(
        .WIDTH(8),
        .DEPTH(MEM_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

endmodule

@@ src/flash_backup_command_engine_top.sv @@
// Top level of the flash backup command engine.
//
// Usage: raise start with i_req_type/i_offset/i_wdata; the access is taken at a
// clock edge where start is high and busy is low. Each read gives one byte on
// o_rdata, marked by o_strobe for exactly one cycle; writes give nothing.
// The receiver cannot stall the result strobe.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 flash kind, 1 chip id), only while the engine is idle; the user must
// keep to this; the block does not enforce it. A read's strobe is high in the
// cycle after the back end pops it from the command queue. A byte program
// ends in the back end's idle state, ready for the next command; a read
// holds its read state. A four-entry command queue lets accesses be taken
// while it works. Sector erase locates its sector via the seek state, then
// fills it one byte per cycle: SECTOR_BYTES bytes, fewer where clipped at
// the end of the store. Chip erase fills MEM_BYTES bytes. busy rises when
// the queue is full. Reset: after i_rst_n the store is filled with 0xFF, one
// byte per cycle, with busy high; mode idle, bank 0, kind 128 KiB.
module flash_backup_command_engine_top #(
    parameter int unsigned MEM_BYTES    = fbce_pkg::MEM_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = fbce_pkg::SECTOR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [15:0] i_offset,
    input  logic [7:0]  i_wdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [7:0]  o_rdata
);
    import fbce_pkg::*;

    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;
    logic clearing;

    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    fbce_front #(
        .MEM_BYTES(MEM_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_offset   (i_offset),
        .i_wdata    (i_wdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    fbce_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    fbce_back #(
        .MEM_BYTES   (MEM_BYTES),
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_clearing(clearing),
        .o_strobe  (o_strobe),
        .o_rdata   (o_rdata)
    );

endmodule

@@ tb/sv/tb_flash_backup_command_engine_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the flash backup command engine top level.
module tb_flash_backup_command_engine_top;
    import fbce_pkg::*;

    localparam int unsigned MEM_BYTES    = MEM_BYTES_DEF;
    localparam int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF;
    localparam int unsigned BANK_SPAN    = 32'h10000;

    // Command interface addresses, keys and command codes
    localparam logic [15:0] ADDR_CMD    = 16'h5555;
    localparam logic [15:0] ADDR_ACK    = 16'h2AAA;
    localparam logic [15:0] OFF_MFR     = 16'h0000;
    localparam logic [15:0] OFF_DEV     = 16'h0001;
    localparam logic [15:0] OFF_BANK    = 16'h0000;
    localparam logic [7:0]  KEY_FIRST   = 8'hAA;
    localparam logic [7:0]  KEY_SECOND  = 8'h55;
    localparam logic [7:0]  CMD_ID      = 8'h90;
    localparam logic [7:0]  CMD_RESET   = 8'hF0;
    localparam logic [7:0]  CMD_ERASE   = 8'h80;
    localparam logic [7:0]  CMD_CHIP    = 8'h10;
    localparam logic [7:0]  CMD_PROGRAM = 8'hA0;
    localparam logic [7:0]  CMD_BANK    = 8'hB0;
    localparam logic [7:0]  CMD_SECTOR  = 8'h30;
    localparam logic [1:0]  KIND_RSVD   = 2'd3;
    localparam logic [15:0] ID_RESET    = 16'd2498;

    // Erases are slow; cap how many the random part may cause
    localparam int CHIP_ERASE_MAX   = 2;
    localparam int SECTOR_ERASE_MAX = 40;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_ID, MODE_ERASE, MODE_PROGRAM, MODE_BANK
    } t_mode;

    typedef struct packed {
        logic        rw;
        logic [15:0] off;
        logic [7:0]  data;
    } t_access;

    typedef struct packed {
        logic        rw;
        logic [15:0] off;
        logic [7:0]  data;
        logic        typed;
        logic [7:0]  want;
    } t_row;

    typedef struct packed {
        logic [1:0]  kind;
        logic        rand_id;
        logic [15:0] id;
        logic [10:0] n;
        logic        idle;
    } t_phase;

    typedef struct {
        logic [7:0] val;
        int         tag;
    } t_rd_exp;

    // Directed accesses: all commands but the exit, ID bytes, banking, both erases
    localparam t_row DIR_TAB [25] = '{
        '{REQ_READ,  16'h0000, 8'h00,       1'b1, 8'hFF},
        '{REQ_READ,  16'hFFFF, 8'h00,       1'b1, 8'hFF},
        '{REQ_WRITE, ADDR_CMD, KEY_FIRST,   1'b0, 8'h00},
        '{REQ_WRITE, ADDR_ACK, KEY_SECOND,  1'b0, 8'h00},
        '{REQ_WRITE, ADDR_CMD, CMD_ID,      1'b0, 8'h00},
        '{REQ_READ,  OFF_MFR,  8'h00,       1'b1, 8'hC2},
        '{REQ_READ,  OFF_DEV,  8'h00,       1'b1, 8'h09},
        '{REQ_READ,  16'h0002, 8'h00,       1'b0, 8'h00},
        '{REQ_WRITE, ADDR_CMD, KEY_FIRST,   1'b0, 8'h00},
        '{REQ_WRITE, ADDR_ACK, KEY_SECOND,  1'b0, 8'h00},
        '{REQ_WRITE, ADDR_CMD, CMD_PROGRAM, 1'b0, 8'h00},
        '{REQ_WRITE, 16'hFFFF, 8'h5A,       1'b0, 8'h00},
        '{REQ_READ,  16'hFFFF, 8'h00,       1'b0, 8'h00},
        '{REQ_WRITE, ADDR_CMD, KEY_FIRST,   1'b0, 8'h00},
        '{REQ_WRITE, ADDR_ACK, KEY_SECOND,  1'b0, 8'h00},
        '{REQ_WRITE, ADDR_CMD, CMD_BANK,    1'b0, 8'h00},
        '{REQ_WRITE, OFF_BANK, 8'hFF,       1'b0, 8'h00},
        '{REQ_READ,  16'hFFFF, 8'h00,       1'b1, 8'hFF},
        '{REQ_WRITE, ADDR_CMD, KEY_FIRST,   1'b0, 8'h00},
        '{REQ_WRITE, ADDR_ACK, KEY_SECOND,  1'b0, 8'h00},
        '{REQ_WRITE, ADDR_CMD, CMD_ERASE,   1'b0, 8'h00},
        '{REQ_WRITE, 16'hF000, CMD_SECTOR,  1'b0, 8'h00},
        '{REQ_WRITE, ADDR_CMD, KEY_FIRST,   1'b0, 8'h00},
        '{REQ_WRITE, ADDR_ACK, KEY_SECOND,  1'b0, 8'h00},
        '{REQ_WRITE, ADDR_CMD, CMD_CHIP,    1'b0, 8'h00}
    };

    // Random phases, each under its own part kind and chip id
    localparam t_phase PHASES [7] = '{
        '{KIND_64K,  1'b0, 16'h0000, 11'd150, 1'b1},
        '{KIND_NONE, 1'b0, 16'hFFFF, 11'd80,  1'b1},
        '{KIND_128K, 1'b1, 16'h0000, 11'd200, 1'b1},
        '{KIND_RSVD, 1'b1, 16'h0000, 11'd60,  1'b1},
        '{KIND_64K,  1'b1, 16'h0000, 11'd200, 1'b1},
        '{KIND_128K, 1'b0, 16'hFFFF, 11'd250, 1'b1},
        '{KIND_128K, 1'b1, 16'h0000, 11'd185, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [15:0] i_offset;
    logic [7:0]  i_wdata;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        o_strobe;
    logic [7:0]  o_rdata;

    // Shadow of the chip
    logic [7:0]  flash_img [MEM_BYTES];
    t_mode       mode_q;
    logic        bank_q;
    logic [7:0]  key_a;
    logic [7:0]  key_b;
    logic [1:0]  kind_q;
    logic [15:0] id_q;
    int          chip_left;
    int          sector_left;

    t_rd_exp     read_q [$];
    t_access     plan_q [$];
    logic [15:0] hot_q [$];
    int          err_cnt = 0;
    int          n_sent = 0;
    bit          idle_on = 1'b1;
    int          calm = 0;

    flash_backup_command_engine_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_offset    (i_offset),
        .i_wdata     (i_wdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_rdata     (o_rdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        err_cnt++;
        if (err_cnt <= 200)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic flash_reset();
        foreach (flash_img[k])
            flash_img[k] = 8'hFF;
        mode_q      = MODE_IDLE;
        bank_q      = 1'b0;
        key_a       = 8'h00;
        key_b       = 8'h00;
        kind_q      = KIND_128K;
        id_q        = ID_RESET;
        chip_left   = CHIP_ERASE_MAX;
        sector_left = SECTOR_ERASE_MAX;
    endtask

    function automatic bit kind_ok();
        return kind_q == KIND_64K || kind_q == KIND_128K;
    endfunction

    // Bank plus offset, wrapped at the part size
    function automatic int unsigned flash_addr(logic [15:0] off);
        int unsigned span;
        span = (kind_q == KIND_64K) ? 65536 : 131072;
        if (span > MEM_BYTES)
            span = MEM_BYTES;
        return ((bank_q ? BANK_SPAN : 0) + off) % span;
    endfunction

    task automatic sector_wipe(int unsigned addr);
        int unsigned first;
        int unsigned last;
        first = addr - addr % SECTOR_BYTES;
        last  = first + SECTOR_BYTES;
        if (last > MEM_BYTES)
            last = MEM_BYTES;
        for (int unsigned k = first; k < last; k++)
            flash_img[k] = 8'hFF;
        sector_left--;
    endtask

    // Effect of one write on the shadow state
    task automatic flash_write(logic [15:0] off, logic [7:0] data);
        if (mode_q == MODE_PROGRAM) begin
            flash_img[flash_addr(off)] = data;
            mode_q = MODE_IDLE;
        end else if (off == ADDR_CMD) begin
            if (key_a == KEY_FIRST && key_b == KEY_SECOND) begin
                case (data)
                    CMD_ID:      mode_q = MODE_ID;
                    CMD_RESET:   mode_q = MODE_IDLE;
                    CMD_ERASE:   mode_q = MODE_ERASE;
                    CMD_PROGRAM: mode_q = MODE_PROGRAM;
                    CMD_BANK:    mode_q = MODE_BANK;
                    CMD_CHIP: begin
                        if (mode_q == MODE_ERASE) begin
                            foreach (flash_img[k])
                                flash_img[k] = 8'hFF;
                            chip_left--;
                        end
                    end
                    default: ;
                endcase
                key_a = 8'h00;
                key_b = 8'h00;
            end else begin
                key_a = data;
            end
        end else if (off == ADDR_ACK) begin
            key_b = data;
        end else if (off == OFF_BANK && mode_q == MODE_BANK) begin
            bank_q = data[0];
            mode_q = MODE_IDLE;
        end else if (mode_q == MODE_ERASE && data == CMD_SECTOR) begin
            sector_wipe(flash_addr(off));
        end
    endtask

    function automatic logic [7:0] flash_read(logic [15:0] off);
        if (!kind_ok())
            return 8'h00;
        if (mode_q == MODE_ID && off == OFF_DEV)
            return id_q[15:8];
        if (mode_q == MODE_ID && off == OFF_MFR)
            return id_q[7:0];
        return flash_img[flash_addr(off)];
    endfunction

    // Turn an erase into a harmless write once its budget is spent
    function automatic logic [7:0] tame(logic rw, logic [15:0] off, logic [7:0] data);
        if (rw != REQ_WRITE || !kind_ok() || mode_q != MODE_ERASE)
            return data;
        if (off == ADDR_CMD) begin
            if (data == CMD_CHIP && key_a == KEY_FIRST && key_b == KEY_SECOND && chip_left <= 0)
                return CMD_RESET;
        end else if (off != ADDR_ACK && data == CMD_SECTOR && sector_left <= 0) begin
            return data + 8'd1;
        end
        return data;
    endfunction

    // Offsets lean toward programmed bytes and the command addresses
    function automatic logic [15:0] pick_off();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30 && hot_q.size() > 0)
            return hot_q[$urandom_range(0, hot_q.size() - 1)];
        if (r < 45) begin
            case ($urandom_range(0, 5))
                0:       return OFF_MFR;
                1:       return OFF_DEV;
                2:       return ADDR_CMD;
                3:       return ADDR_ACK;
                4:       return 16'hFFFF;
                default: return 16'h8000;
            endcase
        end
        return 16'($urandom());
    endfunction

    task automatic push_wr(logic [15:0] off, logic [7:0] data);
        plan_q.push_back('{REQ_WRITE, off, data});
    endtask

    task automatic push_rd(logic [15:0] off);
        plan_q.push_back('{REQ_READ, off, 8'($urandom())});
    endtask

    task automatic push_unlock();
        push_wr(ADDR_CMD, KEY_FIRST);
        push_wr(ADDR_ACK, KEY_SECOND);
    endtask

    task automatic remember(logic [15:0] off);
        hot_q.push_back(off);
        if (hot_q.size() > 8)
            void'(hot_q.pop_front());
    endtask

    // Queue up one short burst: a command sequence, a broken unlock pair, reads or one stray write
    task automatic plan_burst();
        int          pick;
        logic [15:0] off;
        logic [7:0]  cmd;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            push_unlock();
            case ($urandom_range(0, 7))
                0: begin
                    push_wr(ADDR_CMD, CMD_ID);
                    push_rd(OFF_MFR);
                    push_rd(OFF_DEV);
                    push_rd(pick_off());
                end
                1: begin
                    push_wr(ADDR_CMD, CMD_RESET);
                    push_rd(pick_off());
                end
                2: begin
                    push_wr(ADDR_CMD, CMD_ERASE);
                    off = 16'($urandom());
                    case ($urandom_range(0, 3))
                        0, 1: begin
                            push_wr(off, CMD_SECTOR);
                            push_rd(off);
                            push_rd(off ^ 16'h0800);
                        end
                        2: begin
                            push_unlock();
                            push_wr(ADDR_CMD, CMD_CHIP);
                            push_rd(off);
                        end
                        default: ;
                    endcase
                end
                3: push_wr(ADDR_CMD, CMD_CHIP);
                4, 7: begin
                    push_wr(ADDR_CMD, CMD_PROGRAM);
                    off = pick_off();
                    push_wr(off, 8'($urandom()));
                    push_rd(off);
                    remember(off);
                end
                5: begin
                    push_wr(ADDR_CMD, CMD_BANK);
                    push_wr(($urandom_range(0, 3) != 0) ? OFF_BANK : pick_off(), 8'($urandom()));
                    push_rd(pick_off());
                end
                default: begin
                    push_wr(ADDR_CMD, 8'($urandom()));
                    push_rd(pick_off());
                end
            endcase
        end else if (pick < 50) begin
            // unlock pairs with a wrong key or in the wrong order
            cmd = ($urandom_range(0, 1) != 0) ? CMD_PROGRAM : 8'($urandom());
            case ($urandom_range(0, 2))
                0: begin
                    push_wr(ADDR_CMD, KEY_FIRST);
                    push_wr(ADDR_ACK, 8'($urandom()));
                end
                1: begin
                    push_wr(ADDR_ACK, KEY_SECOND);
                    push_wr(ADDR_CMD, KEY_FIRST);
                end
                default: begin
                    push_wr(ADDR_CMD, 8'($urandom()));
                    push_wr(ADDR_ACK, KEY_SECOND);
                end
            endcase
            push_wr(ADDR_CMD, cmd);
            push_rd(pick_off());
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 4))
                push_rd(pick_off());
        end else begin
            push_wr(16'($urandom()), ($urandom_range(0, 3) == 0) ? CMD_SECTOR : 8'($urandom()));
        end
    endtask

    // One access transfer; shadow state and expected bytes follow on acceptance
    task automatic send(logic rw, logic [15:0] off, logic [7:0] data,
                        logic typed, logic [7:0] want);
        int      gap;
        t_rd_exp e;
        gap = 0;
        if (idle_on) begin
            if (calm > 0)
                calm--;
            else if ($urandom_range(0, 9) == 0)
                calm = $urandom_range(8, 40);
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 17);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_req_type <= rw;
        i_offset   <= off;
        i_wdata    <= data;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        n_sent++;
        if (rw == REQ_READ) begin
            e.val = typed ? want : flash_read(off);
            e.tag = n_sent;
            read_q.push_back(e);
        end else if (kind_ok()) begin
            flash_write(off, data);
        end
    endtask

    task automatic cfg_write(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FLASH_KIND)
            kind_q = val[1:0];
        else
            id_q = val;
    endtask

    // A read queues behind any erase; once it returns the engine is idle
    task automatic settle();
        send(REQ_READ, pick_off(), 8'h00, 1'b0, 8'h00);
        @(negedge i_clk);
        start <= 1'b0;
        while (read_q.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Read results against the oldest expected byte
    always @(posedge i_clk) begin : read_check
        t_rd_exp head;
        if (i_rst_n && o_strobe) begin
            if (read_q.size() == 0) begin
                report_mismatch($sformatf("read byte %02h with no read pending", o_rdata));
            end else begin
                head = read_q.pop_front();
                if (o_rdata !== head.val)
                    report_mismatch($sformatf("access %0d: read %02h, expected %02h",
                                              head.tag, o_rdata, head.val));
            end
        end
    end

    // Main sequence
    initial begin
        t_access a;
        int      done;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = REQ_READ;
        i_offset    = 16'h0000;
        i_wdata     = 8'h00;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_FLASH_KIND;
        i_cfg_wdata = 16'h0000;
        flash_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TAB[i])
            send(DIR_TAB[i].rw, DIR_TAB[i].off, DIR_TAB[i].data,
                 DIR_TAB[i].typed, DIR_TAB[i].want);

        foreach (PHASES[p]) begin
            settle();
            cfg_write(CFG_FLASH_KIND, {14'd0, PHASES[p].kind});
            cfg_write(CFG_CHIP_ID, PHASES[p].rand_id ? 16'($urandom()) : PHASES[p].id);
            idle_on = PHASES[p].idle;
            plan_q.delete();
            done = 0;
            while (done < int'(PHASES[p].n)) begin
                if (plan_q.size() == 0)
                    plan_burst();
                a = plan_q.pop_front();
                a.data = tame(a.rw, a.off, a.data);
                done++;
                send(a.rw, a.off, a.data, 1'b0, 8'h00);
            end
        end
        settle();

        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: covers the reset fill, a few chip erases and the sector erases
    initial begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ flash_backup_command_engine_top.f @@
src/fbce_pkg.sv
src/fbce_ram.sv
src/fbce_front.sv
src/fbce_queue.sv
src/fbce_back.sv
src/flash_backup_command_engine_top.sv
tb/sv/tb_flash_backup_command_engine_top.sv
